>>> src/assert_macros.svh
// Assertion macros shared by the keypad chord tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while in reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while in reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/kcet_pkg.sv
// Package with the command types and constants of the keypad chord tracker.
package kcet_pkg;

    localparam int MOD_W      = 4;
    localparam int CHORD_W    = 9;
    localparam int KEY_W      = 4;
    localparam int BUTTON_W   = 4;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 2;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODIFIER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHORD_A  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHORD_B  = 2'd2;

    localparam logic [MOD_W-1:0]   MODIFIER_RESET = 4'd4;
    localparam logic [CHORD_W-1:0] CHORD_A_RESET  = 9'b000010001;
    localparam logic [CHORD_W-1:0] CHORD_B_RESET  = 9'b000010010;

    typedef enum logic [1:0] {
        CMD_SINGLE,
        CMD_CHORD,
        CMD_MACRO_REL
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [KEY_W-1:0]  key;
        logic              is_release;
        logic              macro_sel;
    } cmd_t;

    typedef struct packed {
        logic keys_enabled;
        logic macro_active;
    } front_status_t;

endpackage

>>> src/kcet_front.sv
// Front end: accepts key samples, tracks key state and issues event commands.
module kcet_front
    import kcet_pkg::*;
#(
    parameter int NUM_KEYS   = 9,
    parameter int NUM_MACROS = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [KEY_W-1:0]      key_index,
    input  logic                  key_down,
    input  logic                  q_full,
    output logic                  q_push,
    output cmd_t                  q_cmd,
    output front_status_t         status
);

    logic [MOD_W-1:0]    modifier_reg;
    logic [CHORD_W-1:0]  chord_a_reg;
    logic [CHORD_W-1:0]  chord_b_reg;

    logic [NUM_KEYS-1:0] held_mask_reg, held_mask_next;
    logic                macro_active_reg, macro_active_next;
    logic                keys_enabled_reg, keys_enabled_next;

    logic [NUM_KEYS-1:0] key_hit;
    logic [NUM_KEYS-1:0] chord_a_ext;
    logic [NUM_KEYS-1:0] chord_b_ext;
    logic [NUM_KEYS-1:0] down_mask;
    logic                key_in_range;
    logic                accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Chord patterns only take part on the low key positions.
    always_comb
    begin
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            key_hit[i] = (32'(key_index) == 32'(i));
            if (i < CHORD_W)
            begin
                chord_a_ext[i] = chord_a_reg[i];
                chord_b_ext[i] = chord_b_reg[i];
            end
            else
            begin
                chord_a_ext[i] = 1'b0;
                chord_b_ext[i] = 1'b0;
            end
        end
    end

    assign key_in_range = (32'(key_index) < 32'(NUM_KEYS));
    assign down_mask    = held_mask_reg | key_hit;

    always_comb
    begin
        held_mask_next    = held_mask_reg;
        macro_active_next = macro_active_reg;
        keys_enabled_next = keys_enabled_reg;
        q_push            = 1'b0;
        q_cmd.kind        = CMD_SINGLE;
        q_cmd.key         = key_index;
        q_cmd.is_release  = 1'b0;
        q_cmd.macro_sel   = 1'b0;

        if (accept && key_in_range)
        begin
            if (key_down)
            begin
                held_mask_next = down_mask;
                if ((key_index != modifier_reg) && keys_enabled_reg)
                begin
                    q_push = 1'b1;
                end
                else
                begin
                    keys_enabled_next = 1'b0;
                    if (down_mask == chord_a_ext)
                    begin
                        q_push            = 1'b1;
                        q_cmd.kind        = CMD_CHORD;
                        macro_active_next = 1'b1;
                    end
                    else if ((NUM_MACROS >= 2) && (down_mask == chord_b_ext))
                    begin
                        q_push            = 1'b1;
                        q_cmd.kind        = CMD_CHORD;
                        q_cmd.macro_sel   = 1'b1;
                        macro_active_next = 1'b1;
                    end
                end
            end
            else if ((held_mask_reg & key_hit) != '0)
            begin
                q_push           = 1'b1;
                q_cmd.is_release = 1'b1;
                held_mask_next   = held_mask_reg & ~key_hit;
            end
            else if ((held_mask_reg == '0) && macro_active_reg)
            begin
                q_push            = 1'b1;
                q_cmd.kind        = CMD_MACRO_REL;
                q_cmd.is_release  = 1'b1;
                macro_active_next = 1'b0;
            end
            else if ((held_mask_reg == '0) && !keys_enabled_reg)
            begin
                keys_enabled_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modifier_reg     <= MODIFIER_RESET;
            chord_a_reg      <= CHORD_A_RESET;
            chord_b_reg      <= CHORD_B_RESET;
            held_mask_reg    <= '0;
            macro_active_reg <= 1'b0;
            keys_enabled_reg <= 1'b1;
        end
        else
        begin
            held_mask_reg    <= held_mask_next;
            macro_active_reg <= macro_active_next;
            keys_enabled_reg <= keys_enabled_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MODIFIER: modifier_reg <= cfg_data[MOD_W-1:0];
                    CFG_CHORD_A:  chord_a_reg  <= cfg_data[CHORD_W-1:0];
                    CFG_CHORD_B:  chord_b_reg  <= cfg_data[CHORD_W-1:0];
                    default:      ;
                endcase
            end
        end
    end

    assign status.keys_enabled = keys_enabled_reg;
    assign status.macro_active = macro_active_reg;

endmodule

>>> src/kcet_cmd_queue.sv
// Small command queue between the front end and the event emitter.
module kcet_cmd_queue
    import kcet_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic valid,
    output cmd_t pop_cmd
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (32'(count_reg) == 32'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> src/kcet_back.sv
// Back end: expands each command into button events, one per cycle while out_ready does not stall the output.
module kcet_back
    import kcet_pkg::*;
#(
    parameter int NUM_KEYS   = 9,
    parameter int NUM_MACROS = 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  cmd_t                q_cmd,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [BUTTON_W-1:0] button,
    output logic                is_release,
    output logic                last_event
);

    localparam int CNT_W = $clog2(NUM_KEYS + NUM_MACROS + 1);

    cmd_t                cmd_reg;
    logic                active_reg, active_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic [BUTTON_W-1:0] button_reg;
    logic                is_release_reg;
    logic                last_event_reg;

    logic                slot_free;
    logic                emit;
    logic [31:0]         ev_wide;
    logic                ev_release;
    logic                ev_last;

    assign slot_free = !out_valid_reg || out_ready;
    assign emit      = active_reg && slot_free;

    // A chord command releases every key button and then presses one macro button;
    // a macro release command walks over all macro buttons.
    always_comb
    begin
        ev_wide    = 32'(cmd_reg.key);
        ev_release = cmd_reg.is_release;
        ev_last    = 1'b1;
        case (cmd_reg.kind)
            CMD_SINGLE:
            begin
                ev_wide    = 32'(cmd_reg.key);
                ev_release = cmd_reg.is_release;
                ev_last    = 1'b1;
            end
            CMD_CHORD:
            begin
                if (32'(cnt_reg) < 32'(NUM_KEYS))
                begin
                    ev_wide    = 32'(cnt_reg);
                    ev_release = 1'b1;
                    ev_last    = 1'b0;
                end
                else
                begin
                    ev_wide    = 32'(NUM_KEYS) + 32'(cmd_reg.macro_sel);
                    ev_release = 1'b0;
                    ev_last    = 1'b1;
                end
            end
            CMD_MACRO_REL:
            begin
                ev_wide    = 32'(NUM_KEYS) + 32'(cnt_reg);
                ev_release = 1'b1;
                ev_last    = (32'(cnt_reg) == 32'(NUM_MACROS - 1));
            end
            default:
            begin
                ev_wide    = 32'(cmd_reg.key);
                ev_release = cmd_reg.is_release;
                ev_last    = 1'b1;
            end
        endcase
    end

    assign q_pop = q_valid && (!active_reg || (emit && ev_last));

    always_comb
    begin
        active_next    = active_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (q_pop)
        begin
            active_next = 1'b1;
            cnt_next    = '0;
        end
        else if (emit && ev_last)
        begin
            active_next = 1'b0;
        end
        else if (emit)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_cmd;
        end
        if (emit)
        begin
            button_reg     <= ev_wide[BUTTON_W-1:0];
            is_release_reg <= ev_release;
            last_event_reg <= ev_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign button     = button_reg;
    assign is_release = is_release_reg;
    assign last_event = last_event_reg;

endmodule

>>> src/keypad_chord_event_tracker_unit.sv
// Top level of the keypad chord tracker: front end, command queue and event emitter.
// Key samples are taken one per cycle whenever the two-entry command queue has room;
// the key mask and the enable and macro flags are registered from the transfer.
// Each sample that causes events becomes one command, and the emitter turns commands
// into result transfers at one event per cycle unless out_ready stalls it: a plain
// press or release is one event, a chord match is NUM_KEYS + 1 events, a macro
// release is NUM_MACROS events. The emitter therefore sets the sustained rate, and
// a sample's first event passes the queue entry, the emitter's command register and
// its output register. Samples with key index NUM_KEYS or more are taken and ignored.
`include "assert_macros.svh"

module keypad_chord_event_tracker_unit
    import kcet_pkg::*;
#(
    parameter int NUM_KEYS   = 9,
    parameter int NUM_MACROS = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [KEY_W-1:0]      key_index,
    input  logic                  key_down,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [BUTTON_W-1:0]   button,
    output logic                  is_release,
    output logic                  last_event
);

    logic          q_full;
    logic          q_push;
    cmd_t          q_push_cmd;
    logic          q_pop;
    logic          q_valid;
    cmd_t          q_pop_cmd;
    front_status_t status;

    kcet_front #(
        .NUM_KEYS   (NUM_KEYS),
        .NUM_MACROS (NUM_MACROS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .key_index (key_index),
        .key_down  (key_down),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_push_cmd),
        .status    (status)
    );

    kcet_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_cmd  (q_pop_cmd)
    );

    kcet_back #(
        .NUM_KEYS   (NUM_KEYS),
        .NUM_MACROS (NUM_MACROS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_cmd      (q_pop_cmd),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .button     (button),
        .is_release (is_release),
        .last_event (last_event)
    );

    `ASSERT_IMPLIES(a_queue_no_overflow, q_push, !q_full, "command pushed into a full queue")
    `ASSERT_IMPLIES(a_queue_no_underflow, q_pop, q_valid, "command popped from an empty queue")
    `ASSERT_IMPLIES(a_macro_locks_keys, status.macro_active, !status.keys_enabled,
        "keys enabled while a macro is held")
    `ASSERT_NEXT(a_macro_needs_command, !status.macro_active && !q_push,
        !status.macro_active, "macro flag set without a chord command")

endmodule
